>>> design/gwwb_pkg.sv
`default_nettype none

package gwwb_pkg;

  localparam int DEF_MAX_PIXELS     = 4096;
  localparam int DEF_GAIN_FRAC_BITS = 16;

  // Configuration register and fixed field widths.
  localparam int PIX_CNT_W     = 13;
  localparam int PIX_CNT_RESET = 4096;
  localparam int CHAN_W        = 8;
  localparam int GAIN_W        = 24;
  localparam logic [GAIN_W-1:0] GAIN_MAX = {GAIN_W{1'b1}};
  localparam logic [CHAN_W-1:0] CHAN_MAX = 8'd255;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_EMIT = 1'b1;

  // Channel order in the gain file and in the divider sequence.
  localparam logic [1:0] CH_RED   = 2'd0;
  localparam logic [1:0] CH_GREEN = 2'd1;
  localparam logic [1:0] CH_BLUE  = 2'd2;

endpackage

`default_nettype wire

>>> design/gray_world_white_balance_core.sv
`default_nettype none

// Channel   Direction  Handshake              Payload
// cfg       in         cfg_valid/cfg_ready    cfg_data (pixel_count)
// in        in         in_valid/in_ready      opcode, red_in, green_in, blue_in
// out       out        out_valid/out_ready    red_out, green_out, blue_out, last_pixel
//
// A load beat is written to the frame store as it is accepted. An emit beat's result
// passes the frame store read, the multiply stage and the output register; emits stream
// at one per cycle through them while no result is stalled.
// The first emit of a frame waits for the shared restoring divider: three gains of
// SUM_W + 2 + GAIN_FRAC_BITS steps each.
// Reset is synchronous; the frame store is not cleared and holds nothing until loaded.
// A stalled result freezes the pipeline and holds in_ready low until the beat is taken.
module gray_world_white_balance_core #(
  parameter int MAX_PIXELS     = gwwb_pkg::DEF_MAX_PIXELS,
  parameter int GAIN_FRAC_BITS = gwwb_pkg::DEF_GAIN_FRAC_BITS
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [gwwb_pkg::PIX_CNT_W-1:0] cfg_data,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic                           opcode,
  input  wire logic [gwwb_pkg::CHAN_W-1:0]    red_in,
  input  wire logic [gwwb_pkg::CHAN_W-1:0]    green_in,
  input  wire logic [gwwb_pkg::CHAN_W-1:0]    blue_in,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic [gwwb_pkg::CHAN_W-1:0]         red_out,
  output logic [gwwb_pkg::CHAN_W-1:0]         green_out,
  output logic [gwwb_pkg::CHAN_W-1:0]         blue_out,
  output logic                                last_pixel
);

  import gwwb_pkg::*;

  localparam int CNT_W  = $clog2(MAX_PIXELS + 1);
  localparam int ADDR_W = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
  localparam int SUM_W  = $clog2(MAX_PIXELS * 255 + 1);
  localparam int TOT_W  = SUM_W + 2;
  localparam int DVS_W  = SUM_W + 2;
  localparam int DIVD_W = TOT_W + GAIN_FRAC_BITS;
  localparam int STEP_W = $clog2(DIVD_W);
  localparam int QX_W   = (DIVD_W > GAIN_W) ? DIVD_W : GAIN_W;
  localparam int PIX_W  = 3 * CHAN_W;
  localparam int PROD_W = CHAN_W + GAIN_W;

  typedef enum logic {
    S_RUN,
    S_DIV
  } state_t;

  state_t state;

  logic [PIX_CNT_W-1:0] pixel_count;
  logic [SUM_W-1:0]     red_sum, green_sum, blue_sum;
  logic [CNT_W-1:0]     loaded_count, emitted_count;
  logic [GAIN_W-1:0]    gain [3];
  logic                 gains_ready;

  // Frame store.
  logic [PIX_W-1:0]  frame_store [MAX_PIXELS];
  logic [PIX_W-1:0]  mem_q;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;

  // Divider.
  logic [1:0]        div_ch;
  logic [STEP_W-1:0] div_step;
  logic [DVS_W-1:0]  div_rem;
  logic [DIVD_W-1:0] div_quo;

  // Emit pipeline.
  logic              a_vld, a_last;
  logic              b_vld, b_last;
  logic [PROD_W-1:0] prod [3];

  // Frame length, with zero taken as one and clipped to the store size.
  logic [31:0]      pc_wide;
  logic [CNT_W-1:0] frame_n;

  always_comb begin
    pc_wide = 32'(pixel_count);
    if (pc_wide == 32'd0) begin
      frame_n = CNT_W'(1);
    end else if (pc_wide > 32'(MAX_PIXELS)) begin
      frame_n = CNT_W'(MAX_PIXELS);
    end else begin
      frame_n = CNT_W'(pc_wide);
    end
  end

  logic frame_full, all_sent, advance, need_div;
  logic in_acc, load_acc, emit_acc, new_frame;

  assign frame_full = (loaded_count >= frame_n);
  assign all_sent   = (emitted_count >= frame_n);
  assign advance    = !out_valid || out_ready;
  assign need_div   = in_valid && (opcode == OP_EMIT) && frame_full && !all_sent
                      && !gains_ready;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == S_RUN) && advance && !need_div;
  assign in_acc    = in_valid && in_ready;
  assign load_acc  = in_acc && (opcode == OP_LOAD) && (!frame_full || all_sent);
  assign new_frame = frame_full && all_sent;
  assign emit_acc  = in_acc && (opcode == OP_EMIT) && frame_full && !all_sent;

  assign mem_we    = load_acc;
  assign mem_waddr = new_frame ? '0 : loaded_count[ADDR_W-1:0];

  always_ff @(posedge clk) begin
    if (mem_we) begin
      frame_store[mem_waddr] <= {red_in, green_in, blue_in};
    end
    if (emit_acc) begin
      mem_q <= frame_store[emitted_count[ADDR_W-1:0]];
    end
  end

  // One restoring step per cycle on the channel that div_ch selects.
  logic [SUM_W-1:0]  chan_sum;
  logic [TOT_W-1:0]  total;
  logic [DVS_W-1:0]  divisor;
  logic [DIVD_W-1:0] dividend;
  logic [DVS_W:0]    rem_sh;
  logic [DVS_W-1:0]  rem_sub;
  logic              fits;
  logic [DVS_W-1:0]  rem_next;
  logic [DIVD_W-1:0] quo_next;
  logic [QX_W-1:0]   quo_ext;
  logic [GAIN_W-1:0] gain_new;

  always_comb begin
    case (div_ch)
      CH_RED:   chan_sum = red_sum;
      CH_GREEN: chan_sum = green_sum;
      default:  chan_sum = blue_sum;
    endcase
    total    = TOT_W'(red_sum) + TOT_W'(green_sum) + TOT_W'(blue_sum);
    divisor  = (DVS_W'(chan_sum) << 1) + DVS_W'(chan_sum);
    dividend = {total, {GAIN_FRAC_BITS{1'b0}}};
    rem_sh   = {div_rem, div_quo[DIVD_W-1]};
    // When the divisor fits, the difference is below the divisor, so the low bits suffice.
    rem_sub  = rem_sh[DVS_W-1:0] - divisor;
    fits     = (rem_sh >= {1'b0, divisor});
    rem_next = fits ? rem_sub : rem_sh[DVS_W-1:0];
    quo_next = {div_quo[DIVD_W-2:0], fits};
    quo_ext  = QX_W'(quo_next);
    if (chan_sum == '0) begin
      gain_new = '0;
    end else if (quo_ext > QX_W'(GAIN_MAX)) begin
      gain_new = GAIN_MAX;
    end else begin
      gain_new = quo_ext[GAIN_W-1:0];
    end
  end

  // Scale and saturate from the product registers.
  logic [PROD_W-1:0] sh [3];
  logic [CHAN_W-1:0] sat [3];

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      sh[c]  = prod[c] >> GAIN_FRAC_BITS;
      sat[c] = (|sh[c][PROD_W-1:CHAN_W]) ? CHAN_MAX : sh[c][CHAN_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_RUN;
      pixel_count   <= PIX_CNT_W'(PIX_CNT_RESET);
      red_sum       <= '0;
      green_sum     <= '0;
      blue_sum      <= '0;
      loaded_count  <= '0;
      emitted_count <= '0;
      gains_ready   <= 1'b0;
      div_ch        <= CH_RED;
      div_step      <= '0;
      a_vld         <= 1'b0;
      b_vld         <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        pixel_count <= cfg_data;
      end

      unique case (state)
        S_RUN: begin
          if (need_div && advance) begin
            state    <= S_DIV;
            div_ch   <= CH_RED;
            div_step <= '0;
            div_rem  <= '0;
            div_quo  <= dividend;
          end
        end
        S_DIV: begin
          div_rem  <= rem_next;
          div_quo  <= quo_next;
          div_step <= div_step + STEP_W'(1);
          if (div_step == STEP_W'(DIVD_W - 1)) begin
            gain[div_ch] <= gain_new;
            div_step     <= '0;
            div_rem      <= '0;
            if (div_ch == CH_BLUE) begin
              gains_ready <= 1'b1;
              state       <= S_RUN;
            end else begin
              div_ch  <= div_ch + 2'd1;
              div_quo <= dividend;
            end
          end
        end
        default: state <= S_RUN;
      endcase

      // Gains are not cleared on a new frame; they are only read once recomputed.
      if (load_acc) begin
        if (new_frame) begin
          red_sum       <= SUM_W'(red_in);
          green_sum     <= SUM_W'(green_in);
          blue_sum      <= SUM_W'(blue_in);
          loaded_count  <= CNT_W'(1);
          emitted_count <= '0;
          gains_ready   <= 1'b0;
        end else begin
          red_sum      <= red_sum + SUM_W'(red_in);
          green_sum    <= green_sum + SUM_W'(green_in);
          blue_sum     <= blue_sum + SUM_W'(blue_in);
          loaded_count <= loaded_count + CNT_W'(1);
        end
      end

      if (emit_acc) begin
        emitted_count <= emitted_count + CNT_W'(1);
      end

      if (advance) begin
        a_vld     <= emit_acc;
        a_last    <= (emitted_count + CNT_W'(1)) == frame_n;
        b_vld     <= a_vld;
        b_last    <= a_last;
        prod[0]   <= PROD_W'(mem_q[3*CHAN_W-1:2*CHAN_W]) * PROD_W'(gain[0]);
        prod[1]   <= PROD_W'(mem_q[2*CHAN_W-1:CHAN_W]) * PROD_W'(gain[1]);
        prod[2]   <= PROD_W'(mem_q[CHAN_W-1:0]) * PROD_W'(gain[2]);
        out_valid <= b_vld;
        red_out    <= sat[0];
        green_out  <= sat[1];
        blue_out   <= sat[2];
        last_pixel <= b_last;
      end
    end
  end

endmodule

`default_nettype wire

>>> design/gwwb_checker.sv
`default_nettype none

module gwwb_checker (
  input wire logic                           clk,
  input wire logic                           rst,
  input wire logic                           cfg_valid,
  input wire logic                           cfg_ready,
  input wire logic                           in_ready,
  input wire logic                           out_valid,
  input wire logic                           out_ready,
  input wire logic [gwwb_pkg::CHAN_W-1:0]    red_out,
  input wire logic [gwwb_pkg::CHAN_W-1:0]    green_out,
  input wire logic [gwwb_pkg::CHAN_W-1:0]    blue_out,
  input wire logic                           last_pixel
);

  import gwwb_pkg::*;

  // A waiting result keeps its beat until taken.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(red_out) && $stable(green_out)
                                && $stable(blue_out) && $stable(last_pixel))
    else $error("result payload changed while stalled");

  // The pipeline freezes behind a stalled result, so no new item may enter.
  a_stall_blocks_input: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !in_ready)
    else $error("input accepted while the result was stalled");

  a_reset_clears_out: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid right after reset");

  a_cfg_always_ready: assert property (@(posedge clk) disable iff (rst)
    cfg_valid |-> cfg_ready)
    else $error("configuration write refused");

endmodule

bind gray_world_white_balance_core gwwb_checker u_gwwb_checker (
  .clk        (clk),
  .rst        (rst),
  .cfg_valid  (cfg_valid),
  .cfg_ready  (cfg_ready),
  .in_ready   (in_ready),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .red_out    (red_out),
  .green_out  (green_out),
  .blue_out   (blue_out),
  .last_pixel (last_pixel)
);

`default_nettype wire

>>> dv/gray_world_white_balance_core_tb.sv
`timescale 1ns / 100ps

module gray_world_white_balance_core_tb;
  import gwwb_pkg::*;

  localparam int MAX_PIX     = DEF_MAX_PIXELS;
  localparam int IDX_W       = $clog2(MAX_PIX);
  localparam int FRAC_BITS   = DEF_GAIN_FRAC_BITS;
  localparam int STALL_LIMIT = 2000;
  localparam int PHASE_BEATS = 380;

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
    logic              last_px;
  } balanced_px_t;

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [PIX_CNT_W-1:0] cfg_data;
  logic                 in_valid;
  logic                 in_ready;
  logic                 opcode;
  logic [CHAN_W-1:0]    red_in;
  logic [CHAN_W-1:0]    green_in;
  logic [CHAN_W-1:0]    blue_in;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [CHAN_W-1:0]    red_out;
  logic [CHAN_W-1:0]    green_out;
  logic [CHAN_W-1:0]    blue_out;
  logic                 last_pixel;

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int error_count    = 0;
  int idle_cycles    = 0;
  int useful_beats   = 0;
  int loads_stored   = 0;
  int frames_started = 0;
  int pixels_checked = 0;

  // Predicted block state.
  logic [PIX_CNT_W-1:0] frame_size_reg;
  logic [3*CHAN_W-1:0]  frame_mem [MAX_PIX];
  logic [19:0]          red_acc, green_acc, blue_acc;
  int unsigned          n_loaded, n_emitted;
  logic [GAIN_W-1:0]    red_gain, green_gain, blue_gain;
  bit                   gains_valid;
  balanced_px_t         balanced_q [$];

  always #4 clk = ~clk;

  gray_world_white_balance_core i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .opcode    (opcode),
    .red_in    (red_in),
    .green_in  (green_in),
    .blue_in   (blue_in),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .red_out   (red_out),
    .green_out (green_out),
    .blue_out  (blue_out),
    .last_pixel(last_pixel)
  );

  function automatic int unsigned active_frame_len();
    int unsigned n;
    n = 32'(frame_size_reg);
    if (n == 0) return 1;
    if (n > MAX_PIX) return MAX_PIX;
    return n;
  endfunction

  function automatic bit pixel_ready();
    return n_loaded >= active_frame_len() && n_emitted < active_frame_len();
  endfunction

  function automatic void clear_frame();
    red_acc     = '0;
    green_acc   = '0;
    blue_acc    = '0;
    n_loaded    = 0;
    n_emitted   = 0;
    red_gain    = '0;
    green_gain  = '0;
    blue_gain   = '0;
    gains_valid = 1'b0;
  endfunction

  function automatic logic [GAIN_W-1:0] channel_gain(input longint unsigned total,
                                                      input longint unsigned chan);
    longint unsigned quot;
    if (chan == 0) return '0;
    quot = (total << FRAC_BITS) / (3 * chan);
    if (quot > 64'(GAIN_MAX)) return GAIN_MAX;
    return quot[GAIN_W-1:0];
  endfunction

  function automatic logic [CHAN_W-1:0] apply_gain(input logic [CHAN_W-1:0] level,
                                                    input logic [GAIN_W-1:0] gain);
    longint unsigned prod;
    prod = 64'(level);
    prod = (prod * 64'(gain)) >> FRAC_BITS;
    if (prod > 64'(CHAN_MAX)) return CHAN_MAX;
    return prod[CHAN_W-1:0];
  endfunction

  // Updates the predicted state for one accepted beat and queues the balanced
  // pixel it produces, if any.
  function automatic void predict_beat(input logic op, input logic [CHAN_W-1:0] r, g, b);
    int unsigned     len;
    longint unsigned total;
    logic [23:0]     px;
    balanced_px_t    res;
    len = active_frame_len();
    if (op == OP_LOAD) begin
      if (n_loaded >= len) begin
        if (n_emitted < len) return;
        clear_frame();
      end
      if (n_loaded == 0) frames_started++;
      frame_mem[IDX_W'(n_loaded)] = {r, g, b};
      red_acc   += 20'(r);
      green_acc += 20'(g);
      blue_acc  += 20'(b);
      n_loaded++;
      loads_stored++;
      useful_beats++;
      return;
    end
    if (!pixel_ready()) return;
    if (!gains_valid) begin
      total       = 64'(red_acc) + 64'(green_acc) + 64'(blue_acc);
      red_gain    = channel_gain(total, 64'(red_acc));
      green_gain  = channel_gain(total, 64'(green_acc));
      blue_gain   = channel_gain(total, 64'(blue_acc));
      gains_valid = 1'b1;
    end
    px = frame_mem[IDX_W'(n_emitted)];
    n_emitted++;
    res.red     = apply_gain(px[23:16], red_gain);
    res.green   = apply_gain(px[15:8], green_gain);
    res.blue    = apply_gain(px[7:0], blue_gain);
    res.last_px = (n_emitted == len);
    balanced_q.push_back(res);
    useful_beats++;
  endfunction

  function automatic void check_field(input string name, input logic [CHAN_W-1:0] want, got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      error_count++;
    end
  endfunction

  function automatic int unsigned pick_style();
    return ($urandom_range(9) < 4) ? 0 : $urandom_range(4);
  endfunction

  function automatic logic [CHAN_W-1:0] rand_level();
    return CHAN_W'($urandom_range(255));
  endfunction

  function automatic logic [CHAN_W-1:0] pick_level(input int unsigned style);
    case (style)
      0: return CHAN_W'($urandom_range(255));
      1: return CHAN_W'($urandom_range(15));
      2: return CHAN_W'($urandom_range(255, 240));
      3: return ($urandom_range(1) != 0) ? CHAN_MAX : '0;
      default: return '0;
    endcase
  endfunction

  function automatic logic [PIX_CNT_W-1:0] pick_frame_size();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 70) return PIX_CNT_W'($urandom_range(8, 1));
    if (roll < 90) return PIX_CNT_W'($urandom_range(40, 9));
    if (roll < 95) return PIX_CNT_W'($urandom_range(300, 41));
    if (roll < 98) return '0;
    return PIX_CNT_W'(1);
  endfunction

  task automatic send_beat(input logic op, input logic [CHAN_W-1:0] r, g, b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    opcode   <= op;
    red_in   <= r;
    green_in <= g;
    blue_in  <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_beat(op, r, g, b);
  endtask

  task automatic hold_until_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (balanced_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_frame_size(input logic [PIX_CNT_W-1:0] value);
    hold_until_drained();
    // Emits that produce nothing may still be in the pipeline.
    repeat (8) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid      <= 1'b0;
    frame_size_reg  = value;
  endtask

  task automatic test_reset_frame_length();
    // The reset frame length is the whole store, so three loads leave the frame open.
    send_beat(OP_LOAD, 8'd255, 8'd0, 8'd128);
    send_beat(OP_LOAD, 8'd0, 8'd255, 8'd1);
    send_beat(OP_LOAD, 8'd17, 8'd34, 8'd255);
    send_beat(OP_EMIT, 8'd0, 8'd0, 8'd0);
    write_frame_size(PIX_CNT_W'(3));
    // The fourth emit comes after the last pixel and gets nothing.
    repeat (4) send_beat(OP_EMIT, CHAN_MAX, CHAN_MAX, CHAN_MAX);
  endtask

  task automatic test_gain_corners();
    // A red sum of one against bright green and blue drives the red gain past its maximum.
    send_beat(OP_LOAD, 8'd1, 8'd255, 8'd255);
    send_beat(OP_LOAD, 8'd0, 8'd255, 8'd255);
    send_beat(OP_LOAD, 8'd0, 8'd255, 8'd255);
    repeat (3) send_beat(OP_EMIT, 8'd0, 8'd0, 8'd0);
    write_frame_size(PIX_CNT_W'(2));
    // No red at all in this frame, so red comes out as zero.
    send_beat(OP_LOAD, 8'd0, 8'd0, 8'd0);
    send_beat(OP_LOAD, 8'd0, 8'd40, 8'd255);
    repeat (2) send_beat(OP_EMIT, 8'd0, 8'd0, 8'd0);
  endtask

  task automatic test_short_frames();
    write_frame_size('0);
    send_beat(OP_LOAD, 8'd200, 8'd100, 8'd50);
    // The frame is full and not yet emitted, so this load is dropped.
    send_beat(OP_LOAD, 8'd1, 8'd2, 8'd3);
    send_beat(OP_EMIT, 8'd0, 8'd0, 8'd0);
    send_beat(OP_LOAD, 8'd9, 8'd9, 8'd9);
    send_beat(OP_EMIT, 8'd0, 8'd0, 8'd0);
  endtask

  task automatic test_oversize_frame_length();
    // All ones is beyond the store and is clamped to its size, so a few loads
    // leave the frame open and the emit gets nothing.
    write_frame_size('1);
    repeat (12) send_beat(OP_LOAD, rand_level(), rand_level(), rand_level());
    send_beat(OP_EMIT, 8'd0, 8'd0, 8'd0);
    write_frame_size(PIX_CNT_W'(12));
    while (pixel_ready())
      send_beat(OP_EMIT, rand_level(), rand_level(), rand_level());
    send_beat(OP_EMIT, 8'd0, 8'd0, 8'd0);
  endtask

  task automatic test_random_frames(input int beat_goal);
    int          first_beat;
    int unsigned style_r, style_g, style_b;
    first_beat = useful_beats;
    while (useful_beats - first_beat < beat_goal) begin
      if ($urandom_range(2) == 0) write_frame_size(pick_frame_size());
      style_r = pick_style();
      style_g = pick_style();
      style_b = pick_style();
      while (!pixel_ready()) begin
        if ($urandom_range(99) < 6)
          send_beat(OP_EMIT, rand_level(), rand_level(), rand_level());
        else
          send_beat(OP_LOAD, pick_level(style_r), pick_level(style_g), pick_level(style_b));
        if ($urandom_range(149) == 0) write_frame_size(pick_frame_size());
      end
      while (pixel_ready()) begin
        if ($urandom_range(99) < 6)
          send_beat(OP_LOAD, rand_level(), rand_level(), rand_level());
        else
          send_beat(OP_EMIT, rand_level(), rand_level(), rand_level());
        if ($urandom_range(99) < 3) hold_until_drained();
        if ($urandom_range(149) == 0) write_frame_size(pick_frame_size());
      end
      if ($urandom_range(3) == 0) send_beat(OP_EMIT, 8'd0, 8'd0, 8'd0);
    end
  endtask

  always @(posedge clk) begin
    balanced_px_t want;
    if (!rst && out_valid && out_ready) begin
      if (balanced_q.size() == 0) begin
        $error("Balanced pixel %0d/%0d/%0d arrived with none expected",
               red_out, green_out, blue_out);
        error_count++;
      end else begin
        want = balanced_q.pop_front();
        pixels_checked++;
        check_field("red_out", want.red, red_out);
        check_field("green_out", want.green, green_out);
        check_field("blue_out", want.blue, blue_out);
        check_field("last_pixel", CHAN_W'(want.last_px), CHAN_W'(last_pixel));
      end
    end
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else if (idle_cycles == STALL_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else
      idle_cycles <= idle_cycles + 1;
  end

  initial begin
    rst       = 1'b1;
    cfg_valid = 1'b0;
    cfg_data  = '0;
    in_valid  = 1'b0;
    opcode    = OP_LOAD;
    red_in    = '0;
    green_in  = '0;
    blue_in   = '0;
    frame_size_reg = PIX_CNT_W'(PIX_CNT_RESET);
    clear_frame();
    send_idle_pct  <= 30;
    recv_stall_pct <= 77;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    test_reset_frame_length();
    test_gain_corners();
    test_short_frames();
    test_random_frames(PHASE_BEATS);

    send_idle_pct  <= 77;
    recv_stall_pct <= 30;
    test_oversize_frame_length();
    test_random_frames(PHASE_BEATS);

    send_idle_pct  <= 0;
    recv_stall_pct <= 0;
    test_random_frames(PHASE_BEATS);

    hold_until_drained();
    repeat (20) @(posedge clk);
    $display("Stored %0d pixels over %0d frames and checked %0d balanced pixels,",
             loads_stored, frames_started, pixels_checked);
    $display("covering short and oversize frame lengths, gain clipping, zero channels");
    $display("and beats that the block drops.");
    if (error_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
